// ----- rtl/sem_pkg.sv -----
// Shared types, constants and kernel arithmetic for the Sobel edge magnitude unit.
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int ROW_LIMIT     = 4096;
    localparam int QUEUE_DEPTH   = 2;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ML_W       = 8;
    localparam int ROW_W      = 13;
    localparam int GRAD_W     = 11;
    localparam int ROOT_W     = 22;
    localparam int ROOT_TOP   = 20;
    localparam int COEF_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL    = 2'd2;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [ML_W-1:0] MAX_LEVEL_RST    = 8'd255;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [0:2][0:2] t_kernel;
    typedef logic [0:2][0:2][PIX_W-1:0] t_window;

    localparam t_kernel KERN_X = '{'{-3'sd1, 3'sd0, 3'sd1},
                                   '{-3'sd2, 3'sd0, 3'sd2},
                                   '{-3'sd1, 3'sd0, 3'sd1}};
    localparam t_kernel KERN_Y = '{'{-3'sd1, -3'sd2, -3'sd1},
                                   '{ 3'sd0,  3'sd0,  3'sd0},
                                   '{ 3'sd1,  3'sd2,  3'sd1}};

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_end;
    } t_out_item;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
    } t_frame_cfg;

    typedef struct packed {
        logic                     interior;
        logic                     last;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_work;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_READY,
        S_UPDATE
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQUARE,
        B_ROOT,
        B_HOLD
    } t_back_state;

    function automatic logic signed [GRAD_W-1:0] kernel_sum(input t_window win,
                                                            input t_kernel k);
        logic signed [GRAD_W-1:0] acc;
        acc = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                acc = acc + GRAD_W'(k[r][c]) * $signed({3'b000, win[r][c]});
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/sem_front.sv -----
// Front end: raster counters, row store memory, 3x3 window and gradient sums.
module sem_front #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sem_pkg::t_in_item   i_data,
    input  sem_pkg::t_frame_cfg i_cfg,
    output logic                o_push,
    output sem_pkg::t_work      o_work,
    input  logic                i_full
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int WID_X = WID_W + 1;
    localparam int ROW_W = sem_pkg::ROW_W;
    localparam int PIX_W = sem_pkg::PIX_W;

    sem_pkg::t_front_state r_state, n_state;

    logic [COL_W-1:0] r_clr_addr, n_clr_addr;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    sem_pkg::t_window r_win, n_win;
    logic [PIX_W-1:0] r_pix, n_pix;

    logic [2*PIX_W-1:0] r_row_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic               mem_we;
    logic [COL_W-1:0]   mem_waddr;
    logic [2*PIX_W-1:0] mem_wdata;

    logic [WID_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             accept;
    logic             proceed;
    logic             emit;
    logic             interior;
    logic             last;
    logic [COL_W-1:0] pw_in_col, pw_out_col;
    logic [ROW_W-1:0] pw_in_row, pw_out_row;
    logic [WID_W-1:0] in_col_inc, out_col_inc;
    logic [ROW_W-1:0] in_row_bump, out_row_bump;
    logic [PIX_W-1:0] above2, above1;

    always_comb begin
        if (i_cfg.frame_width == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(i_cfg.frame_width) > MAX_WIDTH) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            eff_h = ROW_W'(1);
        end else if (32'(i_cfg.frame_height) > sem_pkg::ROW_LIMIT) begin
            eff_h = ROW_W'(sem_pkg::ROW_LIMIT);
        end else begin
            eff_h = ROW_W'(i_cfg.frame_height);
        end
    end

    // wrap of counters left beyond a narrowed width
    always_comb begin
        in_row_bump  = (r_in_row == '1) ? r_in_row : r_in_row + ROW_W'(1);
        out_row_bump = (r_out_row >= ROW_W'(sem_pkg::ROW_LIMIT)) ? r_out_row
                                                                 : r_out_row + ROW_W'(1);
        if (WID_W'(r_in_col) >= eff_w) begin
            pw_in_col = '0;
            pw_in_row = in_row_bump;
        end else begin
            pw_in_col = r_in_col;
            pw_in_row = r_in_row;
        end
        if (WID_W'(r_out_col) >= eff_w) begin
            pw_out_col = '0;
            pw_out_row = out_row_bump;
        end else begin
            pw_out_col = r_out_col;
            pw_out_row = r_out_row;
        end
    end

    always_comb begin
        above2 = r_rd_data[2*PIX_W-1:PIX_W];
        above1 = r_rd_data[PIX_W-1:0];
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = above2;
        n_win[1][2] = above1;
        n_win[2][2] = r_pix;

        in_col_inc  = WID_W'(r_in_col) + WID_W'(1);
        out_col_inc = WID_W'(r_out_col) + WID_W'(1);

        emit = (r_in_row >= ROW_W'(2)) || (r_in_row == ROW_W'(1) && r_in_col != '0);
        interior = (r_out_col != '0)
                && (WID_X'(r_out_col) + WID_X'(2) <= WID_X'(eff_w))
                && (r_out_row != '0)
                && (r_out_row + ROW_W'(2) <= eff_h);
        last = (r_out_row + ROW_W'(1) >= eff_h) && (out_col_inc >= eff_w);

        o_work.interior = interior;
        o_work.last     = last;
        o_work.gx       = sem_pkg::kernel_sum(n_win, sem_pkg::KERN_X);
        o_work.gy       = sem_pkg::kernel_sum(n_win, sem_pkg::KERN_Y);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sem_pkg::S_CLEAR: begin
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    n_state = sem_pkg::S_READY;
                end
            end
            sem_pkg::S_READY: begin
                if (i_valid) begin
                    n_state = sem_pkg::S_UPDATE;
                end
            end
            sem_pkg::S_UPDATE: begin
                if (!(emit && i_full)) begin
                    n_state = sem_pkg::S_READY;
                end
            end
            default: n_state = sem_pkg::S_CLEAR;
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_stall   = 1'b1;
        accept    = 1'b0;
        proceed   = 1'b0;
        o_push    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_in_col;
        mem_wdata = {above1, r_pix};
        case (r_state)
            sem_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            sem_pkg::S_READY: begin
                o_stall = 1'b0;
                accept  = i_valid;
            end
            sem_pkg::S_UPDATE: begin
                proceed = !(emit && i_full);
                o_push  = emit && !i_full;
                mem_we  = proceed;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // counter updates
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_pix      = r_pix;
        if (r_state == sem_pkg::S_CLEAR) begin
            n_clr_addr = r_clr_addr + COL_W'(1);
        end
        if (accept) begin
            n_in_col  = pw_in_col;
            n_in_row  = pw_in_row;
            n_out_col = pw_out_col;
            n_out_row = pw_out_row;
            n_pix     = i_data.action ? '0 : i_data.pixel_value;
        end
        if (proceed) begin
            if (emit && last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (emit) begin
                    if (out_col_inc >= eff_w) begin
                        n_out_col = '0;
                        n_out_row = out_row_bump;
                    end else begin
                        n_out_col = COL_W'(out_col_inc);
                    end
                end
                if (in_col_inc >= eff_w) begin
                    n_in_col = '0;
                    n_in_row = in_row_bump;
                end else begin
                    n_in_col = COL_W'(in_col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sem_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_win      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            if (proceed) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    // row stores: upper in the high byte, middle in the low byte
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= r_row_mem[pw_in_col];
        end
    end

`ifndef ASSERT_OFF
    a_no_push_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sem_pkg::S_CLEAR) |-> !o_push)
        else $error("work pushed during row store clear");
`endif

endmodule

// ----- rtl/sem_queue.sv -----
// Short work queue between the front end and the magnitude back end.
module sem_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sem_pkg::t_work i_push_data,
    output logic           o_full,
    input  logic           i_pop,
    output sem_pkg::t_work o_pop_data,
    output logic           o_empty
);

    localparam int DEPTH = sem_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sem_pkg::t_work   r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif
`ifndef ASSERT_OFF
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/sem_back.sv -----
// Back end: squares, bit-pair integer square root, clamp and output register.
module sem_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  sem_pkg::t_work             i_work,
    input  logic [sem_pkg::ML_W-1:0]   i_max_level,
    output logic                       o_valid,
    output sem_pkg::t_out_item         o_data,
    input  logic                       i_stall
);

    localparam int ROOT_W = sem_pkg::ROOT_W;
    localparam int SQ_W   = 2 * sem_pkg::GRAD_W;
    localparam int ML_W   = sem_pkg::ML_W;

    sem_pkg::t_back_state r_state, n_state;

    sem_pkg::t_work     r_item, n_item;
    logic [ROOT_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [ROOT_W-1:0]  r_bit, n_bit;
    logic               r_out_valid;
    sem_pkg::t_out_item r_out_data;

    logic signed [SQ_W-1:0] sq_x, sq_y;
    logic [ROOT_W-1:0]      trial;
    logic [ML_W-1:0]        level;
    logic                   out_load;

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sem_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_work.interior ? sem_pkg::B_SQUARE : sem_pkg::B_HOLD;
                end
            end
            sem_pkg::B_SQUARE: n_state = sem_pkg::B_ROOT;
            sem_pkg::B_ROOT: begin
                if (r_bit == ROOT_W'(1)) begin
                    n_state = sem_pkg::B_HOLD;
                end
            end
            sem_pkg::B_HOLD: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = sem_pkg::B_IDLE;
                end
            end
            default: n_state = sem_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            sem_pkg::B_IDLE: o_pop    = !i_empty;
            sem_pkg::B_HOLD: out_load = !r_out_valid || !i_stall;
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_item = r_item;
        n_rem  = r_rem;
        n_root = r_root;
        n_bit  = r_bit;
        sq_x   = r_item.gx * r_item.gx;
        sq_y   = r_item.gy * r_item.gy;
        trial  = r_root + r_bit;
        level  = (r_root > ROOT_W'(i_max_level)) ? i_max_level : r_root[ML_W-1:0];
        case (r_state)
            sem_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_item = i_work;
                    n_root = '0;
                end
            end
            sem_pkg::B_SQUARE: begin
                n_rem  = ROOT_W'($unsigned(sq_x)) + ROOT_W'($unsigned(sq_y));
                n_root = '0;
                n_bit  = ROOT_W'(1) << sem_pkg::ROOT_TOP;
            end
            sem_pkg::B_ROOT: begin
                if (r_rem >= trial) begin
                    n_rem  = r_rem - trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
            end
            default: n_item = r_item;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sem_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
        if (out_load) begin
            r_out_data.edge_value <= level;
            r_out_data.frame_end  <= r_item.last;
        end
    end

`ifndef ASSERT_OFF
    a_root_bit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sem_pkg::B_ROOT) |-> (r_bit != '0))
        else $error("root iteration without a trial bit");
`endif
`ifndef ASSERT_OFF
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sem_pkg::B_HOLD && !r_item.interior) |-> (r_root == '0))
        else $error("border pixel with non-zero magnitude");
`endif

endmodule

// ----- rtl/sobel_edge_magnitude_unit.sv -----
// Top level of the Sobel edge magnitude unit: configuration registers and block wiring.
//
// Input channel (i_valid / o_stall / i_data): one grey pixel or flush item per transfer,
// in raster order. After each frame send width+1 flush items to push out the tail.
// Output channel (o_valid / i_stall / o_data): one edge value per transfer; frame_end
// marks the last pixel of the frame. Results lag the input by width+1 items; the first
// width+1 items of a frame give no result.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 width, 1 height,
// 2 clamp level) in the same cycle. Write only while no item is in flight.
// Throughput: the front end takes an item (row store read), then updates the window
// before it takes the next; the update waits while the queue is full. Interior results
// pass through a shared square root unit of 11 iterations; border results skip it.
// Reset: synchronous, active low. Afterwards the row store memory is cleared one entry
// per cycle, every entry in turn, with o_stall held high; config writes are still taken.
// Output stall: the output register holds its result; a two-entry queue keeps the
// front end running until it fills, then o_stall rises.
module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  sem_pkg::t_in_item                 i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output sem_pkg::t_out_item                o_data,
    input  logic                              i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [sem_pkg::FW_W-1:0] r_frame_width;
    logic [sem_pkg::FH_W-1:0] r_frame_height;
    logic [sem_pkg::ML_W-1:0] r_max_level;

    sem_pkg::t_frame_cfg frame_cfg;
    sem_pkg::t_work      push_work, pop_work;
    logic                push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sem_pkg::FRAME_WIDTH_RST;
            r_frame_height <= sem_pkg::FRAME_HEIGHT_RST;
            r_max_level    <= sem_pkg::MAX_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sem_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[sem_pkg::FW_W-1:0];
                sem_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[sem_pkg::FH_W-1:0];
                sem_pkg::CFG_MAX_LEVEL:    r_max_level    <= i_cfg_data[sem_pkg::ML_W-1:0];
                default: r_max_level <= r_max_level;
            endcase
        end
    end

    assign frame_cfg.frame_width  = r_frame_width;
    assign frame_cfg.frame_height = r_frame_height;

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_cfg   (frame_cfg),
        .o_push  (push),
        .o_work  (push_work),
        .i_full  (full)
    );

    sem_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_work),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_work),
        .o_empty     (empty)
    );

    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_work      (pop_work),
        .i_max_level (r_max_level),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule
